### src/sitda_pkg.sv
package sitda_pkg;

  // default width of the signed input value
  localparam int unsigned INPUT_WIDTH_DEFAULT = 32;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // character codes
  localparam int unsigned CODE_W = 6;
  localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } sitda_state_e;

endpackage

### src/sitda_front.sv
module sitda_front #(
  parameter int unsigned INPUT_WIDTH = sitda_pkg::INPUT_WIDTH_DEFAULT
) (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [INPUT_WIDTH-1:0] value_i,
  output logic                   push_o,
  input  logic                   full_i,
  output logic [INPUT_WIDTH:0]   entry_o
);

  logic                   neg;
  logic [INPUT_WIDTH-1:0] mag;

  // classify sign and take the magnitude; the most negative value stays unsigned 2^(w-1)
  assign neg = value_i[INPUT_WIDTH-1];
  assign mag = neg ? (~value_i + {{(INPUT_WIDTH-1){1'b0}}, 1'b1}) : value_i;

  // transfer into the queue whenever it has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign entry_o    = {neg, mag};

endmodule

### src/sitda_queue.sv
module sitda_queue #(
  parameter int unsigned DATA_W = sitda_pkg::INPUT_WIDTH_DEFAULT + 1,
  parameter int unsigned DEPTH  = sitda_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [DATA_W-1:0] entry_d [DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  wr_idx;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[0];

  // head is always entry zero; a pop shifts the rest down
  always_comb begin
    wr_idx = count_q - {{(CNT_W-1){1'b0}}, pop_i};
    for (int i = 0; i < DEPTH; i++) begin
      if (pop_i && (i < DEPTH - 1)) begin
        entry_d[i] = entry_q[i+1];
      end else begin
        entry_d[i] = entry_q[i];
      end
      if (push_i && (CNT_W'(i) == wr_idx)) begin
        entry_d[i] = data_i;
      end
    end
    count_d = count_q + {{(CNT_W-1){1'b0}}, push_i} - {{(CNT_W-1){1'b0}}, pop_i};
  end

  // occupancy count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  // no pop from empty, no push when full without a pop
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o) |-> pop_i) else $error("queue push while full");
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue count did not follow push");

endmodule

### src/sitda_back.sv
module sitda_back #(
  parameter int unsigned INPUT_WIDTH = sitda_pkg::INPUT_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic                          q_neg_i,
  input  logic [INPUT_WIDTH-1:0]        q_mag_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sitda_pkg::CODE_W-1:0]  char_code_o,
  output logic                          last_o
);

  // decimal digits that a magnitude of INPUT_WIDTH bits can need
  localparam int unsigned NDIG  = (INPUT_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned CNT_W = $clog2(INPUT_WIDTH + 1);
  localparam int unsigned REM_W = $clog2(NDIG + 1);

  sitda_pkg::sitda_state_e state_q, state_d;
  logic [INPUT_WIDTH-1:0]        bin_q, bin_d;
  logic [BCD_W-1:0]              bcd_q, bcd_d;
  logic [BCD_W-1:0]              bcd_adj;
  logic                          neg_q, neg_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [REM_W-1:0]              rem_q, rem_d;
  logic                          out_valid_q, out_valid_d;
  logic [sitda_pkg::CODE_W-1:0]  code_q, code_d;
  logic                          last_q, last_d;
  logic                          out_free;
  logic                          load;
  logic [3:0]                    top_digit;

  assign out_free  = !out_valid_q || out_ready_i;
  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // sequencer: convert, skip leading zeros, then send the sign (negative values only) and the digits
  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    code_d  = code_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    case (state_q)
      sitda_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          bin_d   = q_mag_i;
          neg_d   = q_neg_i;
          bcd_d   = '0;
          cnt_d   = CNT_W'(INPUT_WIDTH);
          state_d = sitda_pkg::ST_CONV;
        end
      end
      sitda_pkg::ST_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[INPUT_WIDTH-1]};
        bin_d = {bin_q[INPUT_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          rem_d   = REM_W'(NDIG);
          state_d = sitda_pkg::ST_SKIP;
        end
      end
      sitda_pkg::ST_SKIP: begin
        if ((top_digit == 4'd0) && (rem_q != REM_W'(1))) begin
          bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
          rem_d = rem_q - REM_W'(1);
        end else if (neg_q) begin
          state_d = sitda_pkg::ST_SIGN;
        end else begin
          state_d = sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_SIGN: begin
        if (out_free) begin
          load    = 1'b1;
          code_d  = sitda_pkg::CHAR_MINUS;
          last_d  = 1'b0;
          state_d = sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_DIGIT: begin
        if (out_free) begin
          load   = 1'b1;
          code_d = sitda_pkg::CHAR_ZERO + {2'b00, top_digit};
          last_d = (rem_q == REM_W'(1));
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          rem_d  = rem_q - REM_W'(1);
          if (rem_q == REM_W'(1)) begin
            state_d = sitda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sitda_pkg::ST_IDLE;
      end
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sitda_pkg::ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = code_q;
  assign last_o      = last_q;

  // checks on the sequencer
  a_pop_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == sitda_pkg::ST_IDLE)) else $error("pop outside idle");
  a_sign_only_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sitda_pkg::ST_SIGN) |-> neg_q) else $error("sign for a positive value");
  a_rem_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == sitda_pkg::ST_SKIP) || (state_q == sitda_pkg::ST_DIGIT)) |-> (rem_q != '0))
    else $error("digit count ran out");
  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (state_q == sitda_pkg::ST_DIGIT) && (rem_q == REM_W'(1)))
    |=> ((state_q == sitda_pkg::ST_IDLE) && last_q && out_valid_q))
    else $error("final digit not marked");

endmodule

### src/signed_int_to_decimal_ascii_top.sv
// Converts one signed two's complement integer per transfer into its decimal text, sent as a run
// of 6-bit ASCII codes, most significant digit first: a leading '-' for negative values, no
// leading zeros, a single '0' for zero, and last_o high on the final character. The most negative
// value prints as its full unsigned magnitude. A small queue between the input side and the
// converter lets the next value be taken while the current one is still being printed. For each
// value the converter takes it from the queue, runs INPUT_WIDTH shift-and-add-3 steps (32 by
// default) of a serial binary to BCD loop, drops leading zero digits one at a time, and then
// sends each character as the output accepts it.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned INPUT_WIDTH = sitda_pkg::INPUT_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [INPUT_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sitda_pkg::CODE_W-1:0]  char_code_o,
  output logic                          last_o
);

  logic                   push;
  logic                   full;
  logic [INPUT_WIDTH:0]   entry_in;
  logic [INPUT_WIDTH:0]   entry_out;
  logic                   q_valid;
  logic                   pop;

  // input side: sign split and magnitude
  sitda_front #(
    .INPUT_WIDTH(INPUT_WIDTH)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (entry_in)
  );

  // decoupling queue
  sitda_queue #(
    .DATA_W(INPUT_WIDTH + 1),
    .DEPTH (sitda_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (entry_out)
  );

  // converter and character sender
  sitda_back #(
    .INPUT_WIDTH(INPUT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_neg_i     (entry_out[INPUT_WIDTH]),
    .q_mag_i     (entry_out[INPUT_WIDTH-1:0]),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RADIX = 10;
  localparam int unsigned IDLE_PCT = 29;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned RAND_ITEMS = 150;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 300000;

  // one character of the expected decimal text
  typedef struct packed {
    logic [sitda_pkg::CODE_W-1:0] code;
    logic                         is_last;
  } text_char_t;

  // expected decimal text of every accepted value, oldest character first
  class decimal_text_board;
    text_char_t expected_chars[$];
    int unsigned errors;
    int unsigned n_checked;

    function void add_value(logic signed [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [3:0] digs[$];
      text_char_t c;
      // the most negative value wraps to its unsigned magnitude here
      mag = v[VALUE_W-1] ? VALUE_W'(-v) : VALUE_W'(v);
      if (v[VALUE_W-1]) begin
        c.code = sitda_pkg::CHAR_MINUS;
        c.is_last = 1'b0;
        expected_chars.push_back(c);
      end
      do begin
        digs.push_front(4'(mag % RADIX));
        mag = mag / RADIX;
      end while (mag != 0);
      foreach (digs[i]) begin
        c.code = sitda_pkg::CODE_W'(sitda_pkg::CHAR_ZERO + digs[i]);
        c.is_last = (i == digs.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [sitda_pkg::CODE_W-1:0] code, logic is_last);
      text_char_t e;
      n_checked++;
      if (expected_chars.size() == 0) begin
        $display("%0t: character with nothing expected: code %0d last %0b",
                 $time, code, is_last);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      if (code !== e.code) begin
        $display("%0t: char_code mismatch: expected %0d, actual %0d", $time, e.code, code);
        errors++;
      end
      if (is_last !== e.is_last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, e.is_last, is_last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [VALUE_W-1:0]    value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [sitda_pkg::CODE_W-1:0] char_code_o;
  logic                         last_o;

  decimal_text_board sb = new;
  bit steady;
  bit hold_req;
  int unsigned n_sent;
  int unsigned n_negative;
  int unsigned cycles;

  signed_int_to_decimal_ascii_top #(
    .INPUT_WIDTH(VALUE_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycles, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // output side: check each character transfer, stall at random or on request
  initial begin : rx_proc
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_char(char_code_o, last_o);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // offer one value, with random idle cycles first unless steady, and note it once transferred
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    if (!steady) begin
      // now and then a long gap so idle time lands on every conversion phase
      gap = ($urandom_range(19) == 0) ? $urandom_range(60, 1) : 0;
      while (gap > 0 || $urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        value_i <= $urandom;
        @(posedge clk_i);
        if (gap > 0) gap--;
      end
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.add_value(v);
    n_sent++;
    if (v[VALUE_W-1]) n_negative++;
  endtask

  // main sequence
  initial begin : main_proc
    logic signed [VALUE_W-1:0] directed[$];
    logic signed [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    int unsigned k;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    value_i = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, zero, digit count boundaries, alternating bit patterns
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 32'sd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
                 32'sd1000000000, 32'sd999999999, -32'sd1000000000, 32'sh5555_5555,
                 32'shAAAA_AAAA, 32'sd12345, -32'sd67890, 32'sd0};
    foreach (directed[i]) send_value(directed[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // receiver holds off while the sender keeps offering
      if (i == 40) hold_req = 1'b1;
      // sender waits for the block to drain, then a stretch with no idling
      if (i == 80) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
        steady = 1'b1;
      end
      if (i == 120) steady = 1'b0;

      case ($urandom_range(9))
        0, 1, 2, 3: v = $urandom;
        4, 5: v = $urandom_range(999);
        6, 7: begin
          // power of ten and its neighbors
          k = $urandom_range(9);
          p = 1;
          repeat (k) p = p * RADIX;
          v = p + $urandom_range(2) - 1;
        end
        8: v = $urandom_range(3) + (($urandom_range(1) != 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFC);
        default: begin
          k = $urandom_range(9);
          p = 1;
          repeat (k) p = p * RADIX;
          v = $urandom_range(p);
        end
      endcase
      // most of the non-extreme classes get negated half the time
      if ($urandom_range(1) != 0 && v[VALUE_W-1] == 1'b0 && v != 32'sh7FFF_FFFF) v = -v;
      send_value(v);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d values (%0d negative) and %0d character transfers,",
             n_sent, n_negative, sb.n_checked);
    $display("with both field extremes, zero, powers of ten, a long output stall and a drain");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
src/sitda_pkg.sv
src/sitda_front.sv
src/sitda_queue.sv
src/sitda_back.sv
src/signed_int_to_decimal_ascii_top.sv
dv/tb.sv
